@@ rtl/teq_pkg.sv @@
// Package with the timer queue sizes, request and status codes.
package teq_pkg;
    localparam int TIMER_SLOTS = 16;
    localparam int SLOT_W = $clog2(TIMER_SLOTS);
    localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

    localparam logic [1:0] REQ_ADD = 2'd0;
    localparam logic [1:0] REQ_CANCEL = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef logic [SLOT_W-1:0] t_slot;
endpackage

@@ rtl/timer_expiry_queue.sv @@
// Top level of the timer expiry queue: slot table, scan sequencer and result register.
//
// Usage: one request item enters on i_valid/o_ready (add, cancel or tick). The block
// answers with a train of result items on o_valid/i_ready: one item per fired timer on
// a tick, then one closing item with last set that carries the status and the ticks to
// the next expiry (-1 when the table is empty).
// Timing: the slot table is held in registers and is visited one slot per cycle by a
// single compare unit. An add or cancel scans the table once to apply the request and
// once for the next expiry, then loads its closing item; an unused request code skips
// the first scan. A tick runs one scan per fired timer plus one that finds nothing more
// due, with a firing between scans, then the next-expiry scan. The block is ready
// again in the cycle after the closing item enters the result register, so it may take
// the next item while that closing item still waits for the receiver.
// Reset clears the tick counter and all slot valid bits; the other slot fields stay
// undefined until written. When the receiver stalls, the result register holds its item
// and the sequencer waits before each firing and before the closing item.
module timer_expiry_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_task_id,
    input  logic [23:0] i_delay,
    input  logic        i_recurring,
    input  logic [15:0] i_run_count,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic        o_fired,
    output logic [15:0] o_fired_id,
    output logic signed [24:0] o_time_to_next,
    output logic        o_last
);
    import teq_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FIND = 3'd1;  // scan for id match and free slot
    localparam logic [2:0] S_DUE = 3'd2;   // scan for the next due timer
    localparam logic [2:0] S_FIRE = 3'd3;  // emit a firing and update the slot
    localparam logic [2:0] S_NEXT = 3'd4;  // scan for the earliest expiry
    localparam logic [2:0] S_DONE = 3'd5;  // emit the closing item

    // Slot table
    logic [TIMER_SLOTS-1:0] r_valid;
    logic [TIMER_SLOTS-1:0] r_pend;
    logic [15:0] r_id [TIMER_SLOTS];
    logic [31:0] r_exp [TIMER_SLOTS];
    logic [23:0] r_dly [TIMER_SLOTS];
    logic [TIMER_SLOTS-1:0] r_rec;
    logic [15:0] r_runs [TIMER_SLOTS];

    logic [2:0]  r_state;
    logic [31:0] r_now;
    logic [CNT_W-1:0] r_idx;
    logic [1:0]  r_req;
    logic [15:0] r_tid;
    logic [23:0] r_tdly;
    logic        r_trec;
    logic [15:0] r_truns;
    logic        r_match_ok, r_free_ok, r_best_ok;
    t_slot       r_match, r_free, r_best;
    logic [31:0] r_key;
    logic [15:0] r_bid;
    logic        r_first;

    logic        r_ov;
    logic [1:0]  r_ost;
    logic        r_ofi, r_olast;
    logic [15:0] r_oid;
    logic [24:0] r_ottn;

    t_slot s;
    logic [31:0] diff, age, dcl;
    logic out_free;
    logic due_s;

    assign s = r_idx[SLOT_W-1:0];
    assign diff = r_exp[s] - r_now;
    assign age = r_now - r_exp[s];
    assign dcl = diff[31] ? 32'd0 : diff;
    assign out_free = !r_ov || i_ready;

    // On the first due scan of a tick the slot is tested directly, later scans use its mark.
    assign due_s = r_first ? (r_valid[s] && (diff == 32'd0 || diff[31]))
                           : (r_valid[s] && r_pend[s]);

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ov;
    assign o_status = r_ost;
    assign o_fired = r_ofi;
    assign o_fired_id = r_oid;
    assign o_time_to_next = r_ottn;
    assign o_last = r_olast;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == S_FIRE && out_free) begin
            r_ov <= 1'b1;
            r_ost <= ST_OK;
            r_ofi <= 1'b1;
            r_oid <= r_id[r_best];
            r_ottn <= '0;
            r_olast <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_ov <= 1'b1;
            r_ofi <= 1'b0;
            r_oid <= '0;
            r_olast <= 1'b1;
            r_ottn <= r_best_ok ? {1'b0, r_key[23:0]} : '1;
            if (r_req == REQ_ADD && !r_match_ok && !r_free_ok) begin
                r_ost <= ST_FULL;
            end else if (r_req == REQ_CANCEL && !r_match_ok) begin
                r_ost <= ST_NOT_FOUND;
            end else begin
                r_ost <= ST_OK;
            end
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    // Sequencer and slot updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_now <= '0;
            r_valid <= '0;
            r_idx <= '0;
            r_first <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_req <= i_req_type;
                        r_tid <= i_task_id;
                        r_tdly <= (i_delay == 24'd0) ? 24'd1 : i_delay;
                        r_trec <= i_recurring;
                        r_truns <= (i_run_count == 16'd0) ? 16'd0 : i_run_count - 16'd1;
                        r_match_ok <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_best_ok <= 1'b0;
                        r_first <= 1'b1;
                        r_idx <= '0;
                        if (i_req_type == REQ_ADD || i_req_type == REQ_CANCEL) begin
                            r_state <= S_FIND;
                        end else if (i_req_type == REQ_TICK) begin
                            r_now <= r_now + 32'd1;
                            r_state <= S_DUE;
                        end else begin
                            r_state <= S_NEXT;
                        end
                    end
                end
                S_FIND: begin
                    if (r_valid[s] && r_id[s] == r_tid && !r_match_ok) begin
                        r_match_ok <= 1'b1;
                        r_match <= s;
                    end
                    if (!r_valid[s] && !r_free_ok) begin
                        r_free_ok <= 1'b1;
                        r_free <= s;
                    end
                    if (r_idx == CNT_W'(TIMER_SLOTS - 1)) begin
                        r_idx <= '0;
                        r_state <= S_NEXT;
                        // Apply add or cancel on the last scan cycle.
                        begin : apply
                            t_slot w;
                            logic hit, fre;
                            hit = r_match_ok || (r_valid[s] && r_id[s] == r_tid);
                            fre = r_free_ok || !r_valid[s];
                            w = r_match_ok ? r_match :
                                (r_valid[s] && r_id[s] == r_tid) ? s :
                                r_free_ok ? r_free : s;
                            if (hit) begin
                                r_match_ok <= 1'b1;
                            end
                            if (r_req == REQ_ADD && (hit || fre)) begin
                                r_valid[w] <= 1'b1;
                                r_id[w] <= r_tid;
                                r_exp[w] <= r_now + {8'd0, r_tdly};
                                r_dly[w] <= r_tdly;
                                r_rec[w] <= r_trec;
                                r_runs[w] <= r_truns;
                                r_match_ok <= 1'b1;
                            end else if (r_req == REQ_CANCEL && hit) begin
                                r_valid[w] <= 1'b0;
                            end
                        end
                    end else begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                end
                S_DUE: begin
                    // First pass marks due timers; later passes only consult r_pend.
                    if (due_s &&
                        (!r_best_ok || age > r_key || (age == r_key && r_id[s] < r_bid))) begin
                        r_best_ok <= 1'b1;
                        r_best <= s;
                        r_key <= age;
                        r_bid <= r_id[s];
                    end
                    if (r_idx == CNT_W'(TIMER_SLOTS - 1)) begin
                        r_idx <= '0;
                        r_first <= 1'b0;
                        if (r_best_ok || due_s) begin
                            r_state <= S_FIRE;
                        end else begin
                            r_state <= S_NEXT;
                        end
                    end else begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                end
                S_FIRE: begin
                    if (out_free) begin
                        r_best_ok <= 1'b0;
                        if (r_rec[r_best] || r_runs[r_best] != 16'd0) begin
                            if (!r_rec[r_best]) begin
                                r_runs[r_best] <= r_runs[r_best] - 16'd1;
                            end
                            r_exp[r_best] <= r_now + {8'd0, r_dly[r_best]};
                        end else begin
                            r_valid[r_best] <= 1'b0;
                        end
                        r_state <= S_DUE;
                    end
                end
                S_NEXT: begin
                    if (r_valid[s] && (!r_best_ok || dcl < r_key)) begin
                        r_best_ok <= 1'b1;
                        r_key <= dcl;
                    end
                    if (r_idx == CNT_W'(TIMER_SLOTS - 1)) begin
                        r_idx <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Pending marks: recorded during the first due scan of a tick, cleared as each fires.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (r_state == S_DUE && r_first) begin
            r_pend[s] <= due_s;
        end else if (r_state == S_FIRE && out_free) begin
            r_pend[r_best] <= 1'b0;
        end
    end
endmodule

@@ verif/tb_timer_expiry_queue.sv @@
// Testbench for the timer expiry queue: random and directed requests checked against a predictor.
`timescale 1ns / 100ps

module tb_timer_expiry_queue;
    import teq_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic [1:0]  status;
        logic        fired;
        logic [15:0] fired_id;
        logic [24:0] time_to_next;
        logic        last;
    } t_timer_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_req_type;
    logic [15:0] i_task_id;
    logic [23:0] i_delay;
    logic        i_recurring;
    logic [15:0] i_run_count;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_status;
    logic        o_fired;
    logic [15:0] o_fired_id;
    logic signed [24:0] o_time_to_next;
    logic        o_last;

    // Predictor state for the timer table.
    logic [31:0] pred_now;
    logic        pred_valid [TIMER_SLOTS];
    logic [15:0] pred_id [TIMER_SLOTS];
    logic [31:0] pred_expire [TIMER_SLOTS];
    logic [23:0] pred_delay [TIMER_SLOTS];
    logic        pred_recurring [TIMER_SLOTS];
    logic [15:0] pred_runs_left [TIMER_SLOTS];

    t_timer_result expected_results [$];
    int error_count;
    int cycle_count;
    logic [15:0] live_ids [$];

    timer_expiry_queue u_top (.*);

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on the cycle count.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic logic [24:0] next_expiry_distance();
        logic        any;
        logic [31:0] best;
        logic [31:0] diff;
        any = 1'b0;
        best = '0;
        for (int s = 0; s < TIMER_SLOTS; s++) begin
            if (pred_valid[s]) begin
                diff = pred_expire[s] - pred_now;
                if (diff[31]) diff = '0;
                if (!any || diff < best) begin
                    best = diff;
                    any = 1'b1;
                end
            end
        end
        return any ? best[24:0] : '1;
    endfunction

    // Works out the result items of one request and updates the predicted table.
    task automatic predict_request(input logic [1:0] req, input logic [15:0] id,
                                   input logic [23:0] dly_in, input logic rec,
                                   input logic [15:0] runs_in);
        logic [1:0]  status;
        logic [23:0] dly;
        logic [15:0] runs;
        logic        due [TIMER_SLOTS];
        logic [31:0] diff;
        logic [31:0] ks;
        logic [31:0] kb;
        int slot;
        int best;
        status = ST_OK;
        dly = (dly_in == 24'd0) ? 24'd1 : dly_in;
        runs = (runs_in == 16'd0) ? 16'd1 : runs_in;
        slot = -1;
        case (req)
            REQ_ADD: begin
                for (int s = 0; s < TIMER_SLOTS && slot < 0; s++)
                    if (pred_valid[s] && pred_id[s] == id) slot = s;
                for (int s = 0; s < TIMER_SLOTS && slot < 0; s++)
                    if (!pred_valid[s]) slot = s;
                if (slot < 0) begin
                    status = ST_FULL;
                end else begin
                    pred_valid[slot] = 1'b1;
                    pred_id[slot] = id;
                    pred_expire[slot] = pred_now + {8'd0, dly};
                    pred_delay[slot] = dly;
                    pred_recurring[slot] = rec;
                    pred_runs_left[slot] = runs - 16'd1;
                end
            end
            REQ_CANCEL: begin
                status = ST_NOT_FOUND;
                for (int s = 0; s < TIMER_SLOTS && slot < 0; s++)
                    if (pred_valid[s] && pred_id[s] == id) begin
                        slot = s;
                        pred_valid[s] = 1'b0;
                        status = ST_OK;
                    end
            end
            REQ_TICK: begin
                pred_now = pred_now + 32'd1;
                for (int s = 0; s < TIMER_SLOTS; s++) begin
                    diff = pred_expire[s] - pred_now;
                    due[s] = pred_valid[s] && (diff == 32'd0 || diff[31]);
                end
                // Fire the most overdue timer first, lower id on a tie.
                forever begin
                    best = -1;
                    for (int s = 0; s < TIMER_SLOTS; s++) begin
                        if (due[s]) begin
                            if (best < 0) begin
                                best = s;
                            end else begin
                                ks = pred_now - pred_expire[s];
                                kb = pred_now - pred_expire[best];
                                if (ks > kb || (ks == kb && pred_id[s] < pred_id[best]))
                                    best = s;
                            end
                        end
                    end
                    if (best < 0) break;
                    due[best] = 1'b0;
                    expected_results.push_back('{ST_OK, 1'b1, pred_id[best], 25'd0, 1'b0});
                    if (pred_recurring[best] || pred_runs_left[best] != 16'd0) begin
                        if (!pred_recurring[best])
                            pred_runs_left[best] = pred_runs_left[best] - 16'd1;
                        pred_expire[best] = pred_now + {8'd0, pred_delay[best]};
                    end else begin
                        pred_valid[best] = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
        expected_results.push_back('{status, 1'b0, 16'd0, next_expiry_distance(), 1'b1});
    endtask

    function automatic int random_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // Sends one request item and predicts its results on acceptance.
    task automatic send_request(input logic [1:0] req, input logic [15:0] id,
                                input logic [23:0] dly, input logic rec,
                                input logic [15:0] runs);
        int gap;
        gap = random_gap();
        // Valid stays low for a random gap after the previous item dropped it.
        repeat (gap + 1) @(posedge i_clk);
        i_valid <= 1'b1;
        i_req_type <= req;
        i_task_id <= id;
        i_delay <= dly;
        i_recurring <= rec;
        i_run_count <= runs;
        do @(posedge i_clk); while (!o_ready);
        predict_request(req, id, dly, rec, runs);
        i_valid <= 1'b0;
    endtask

    // Receiver stalls at random, with a long stall now and then.
    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= (($urandom_range(0, 9) < 7) && (cycle_count[9:6] != 4'd5)) ||
                        (cycle_count[12:10] == 3'd0);
    end

    // Compares each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_timer_result got;
        t_timer_result want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_status, o_fired, o_fired_id, o_time_to_next, o_last};
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", got));
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
                if (got.fired !== want.fired)
                    report_mismatch($sformatf("fired %0d, want %0d", got.fired, want.fired));
                if (got.fired_id !== want.fired_id)
                    report_mismatch($sformatf("fired_id %0d, want %0d",
                                              got.fired_id, want.fired_id));
                if (got.time_to_next !== want.time_to_next)
                    report_mismatch($sformatf("time_to_next %0d, want %0d",
                                              $signed(got.time_to_next),
                                              $signed(want.time_to_next)));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
            end
        end
    end

    task automatic wait_drained();
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Directed: extremes, every request code and each corner case.
    task automatic test_directed();
        send_request(REQ_TICK, 16'd0, 24'd0, 1'b0, 16'd0);
        send_request(REQ_CANCEL, 16'hFFFF, 24'd0, 1'b0, 16'd0);
        send_request(2'd3, 16'hFFFF, 24'hFFFFFF, 1'b1, 16'hFFFF);
        send_request(REQ_ADD, 16'd5, 24'd0, 1'b0, 16'd0);
        send_request(REQ_ADD, 16'hFFFF, 24'hFFFFFF, 1'b1, 16'hFFFF);
        send_request(REQ_ADD, 16'd7, 24'd2, 1'b0, 16'd3);
        send_request(REQ_ADD, 16'd3, 24'd1, 1'b1, 16'd0);
        send_request(REQ_ADD, 16'd5, 24'd1, 1'b0, 16'd2);
        repeat (7) send_request(REQ_TICK, 16'd0, 24'd0, 1'b0, 16'd0);
        send_request(REQ_CANCEL, 16'd3, 24'd0, 1'b0, 16'd0);
        send_request(REQ_CANCEL, 16'd3, 24'd0, 1'b0, 16'd0);
        // Fill the table and overflow it.
        for (int k = 0; k < TIMER_SLOTS + 1; k++)
            send_request(REQ_ADD, 16'(100 + k), 24'd3, 1'b0, 16'd1);
        wait_drained();
        repeat (6) send_request(REQ_TICK, 16'd0, 24'd0, 1'b0, 16'd0);
        send_request(REQ_CANCEL, 16'hFFFF, 24'd0, 1'b0, 16'd0);
    endtask

    // Random traffic: many short timers so ticks fire often, ids from a small pool.
    task automatic test_random(input int count);
        logic [1:0]  req;
        logic [15:0] id;
        logic [23:0] dly;
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) req = REQ_TICK;
            else if (pick < 75) req = REQ_ADD;
            else if (pick < 95) req = REQ_CANCEL;
            else req = 2'd3;
            id = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
            dly = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 6));
            send_request(req, id, dly, 1'($urandom),
                         ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 3)));
            if (n == count / 2) wait_drained();
        end
    endtask

    initial begin
        error_count = 0;
        cycle_count = 0;
        for (int s = 0; s < TIMER_SLOTS; s++) begin
            pred_valid[s] = 1'b0;
            pred_id[s] = '0;
            pred_expire[s] = '0;
            pred_delay[s] = '0;
            pred_recurring[s] = 1'b0;
            pred_runs_left[s] = '0;
        end
        pred_now = '0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req_type = '0;
        i_task_id = '0;
        i_delay = '0;
        i_recurring = 1'b0;
        i_run_count = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(200);
        wait_drained();
        repeat (100) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
